FILE: rtl/dafp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dafp_pkg: shared widths, constants and helpers
// Fixed internal widths of the torsion angle datapath, the CORDIC arctangent
// table and a leading-one search used by the normalizing stages.
// ----------------------------------------------------------------------------
package dafp_pkg;

	localparam int COORD_WIDTH_D     = 24;
	localparam int ANGLE_FRAC_BITS_D = 13;
	localparam int CORDIC_STEPS_D    = 16;

	localparam int ANGLE_W    = 16;   // result port width
	localparam int SV_W       = 16;   // scaled difference vector component
	localparam int PRD_W      = 32;   // 16x16 product
	localparam int N_W        = 32;   // plane normal component
	localparam int XY_W       = 64;   // dot product / CORDIC input before scaling
	localparam int D_W        = 48;   // r1 . P2
	localparam int SQ_W       = 32;   // r2 . r2
	localparam int LEN_W      = 16;   // |r2|
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int CORDIC_W   = 34;   // CORDIC x, y and angle registers
	localparam int ZFRAC      = 30;
	localparam int SV_TOP     = 14;   // scaled vector leading-one position
	localparam int XY_TOP     = 29;   // CORDIC input leading-one position
	localparam int SH_W       = 6;
	localparam int POS_W      = 7;
	localparam logic signed [63:0] PI_Z = 64'sd3373259426;

	typedef struct packed {
		logic deg;      // a plane normal is the zero vector
		logic zero;     // x and y collapsed to zero after scaling
	} flags_t;

	// atan(2^-i) with ZFRAC fraction bits, truncated
	function automatic logic signed [CORDIC_W-1:0] atan_z(input int i);
		logic signed [CORDIC_W-1:0] v;
		case (i)
			0: v = 34'sh03243F6A8;
			1: v = 34'sh01DAC6705;
			2: v = 34'sh00FADBAFC;
			3: v = 34'sh007F56EA6;
			4: v = 34'sh003FEAB76;
			5: v = 34'sh001FFD55B;
			6: v = 34'sh000FFFAAA;
			7: v = 34'sh0007FFF55;
			8: v = 34'sh0003FFFEA;
			9: v = 34'sh0001FFFFD;
			10: v = 34'sh0000FFFFF;
			11: v = 34'sh00007FFFF;
			12: v = 34'sh00003FFFF;
			13: v = 34'sh00001FFFF;
			14: v = 34'sh00000FFFF;
			15: v = 34'sh000007FFF;
			16: v = 34'sh000003FFF;
			17: v = 34'sh000001FFF;
			18: v = 34'sh000000FFF;
			19: v = 34'sh0000007FF;
			20: v = 34'sh0000003FF;
			21: v = 34'sh0000001FF;
			22: v = 34'sh0000000FF;
			23: v = 34'sh00000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	// position of the highest set bit, 0 for a zero word
	function automatic logic [POS_W-1:0] lead_pos(input logic [63:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	// component index helpers for cross products
	function automatic int nxt1(input int c);
		return (c == 2) ? 0 : c + 1;
	endfunction

	function automatic int nxt2(input int c);
		return (c == 0) ? 2 : c - 1;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/dihedral_angle_from_four_points_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points_core: signed torsion angle of four points
// Pipelined kernel: difference vectors, plane normals, dot products, a chain
// of square-root cells for |r2| and a chain of CORDIC cells for atan2.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | beat carries
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_ready, p1_x .. p4_z          | four 3D points Q11.12
//  out     | out_valid, out_ready, angle, degenerate   | angle Q2.13, flag
//
//  One beat per cycle in and out while the output is not stalled; the pipeline depth
//  is set by the square-root and CORDIC cell chains and the other stages.
//  The whole pipeline advances together: it holds while the output register
//  is full and out_ready is low, and in_ready follows that advance.
//  Reset clears only the valid bits; payload registers are left alone.
//  No result is dropped or repeated under any pattern of stalls.
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points_core #(
	parameter int COORD_WIDTH     = dafp_pkg::COORD_WIDTH_D,
	parameter int ANGLE_FRAC_BITS = dafp_pkg::ANGLE_FRAC_BITS_D,
	parameter int CORDIC_STEPS    = dafp_pkg::CORDIC_STEPS_D
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] p1_x,
	input  wire logic signed [COORD_WIDTH-1:0] p1_y,
	input  wire logic signed [COORD_WIDTH-1:0] p1_z,
	input  wire logic signed [COORD_WIDTH-1:0] p2_x,
	input  wire logic signed [COORD_WIDTH-1:0] p2_y,
	input  wire logic signed [COORD_WIDTH-1:0] p2_z,
	input  wire logic signed [COORD_WIDTH-1:0] p3_x,
	input  wire logic signed [COORD_WIDTH-1:0] p3_y,
	input  wire logic signed [COORD_WIDTH-1:0] p3_z,
	input  wire logic signed [COORD_WIDTH-1:0] p4_x,
	input  wire logic signed [COORD_WIDTH-1:0] p4_y,
	input  wire logic signed [COORD_WIDTH-1:0] p4_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [dafp_pkg::ANGLE_W-1:0] angle,
	output logic                               degenerate
);
	import dafp_pkg::*;

	localparam int RW     = COORD_WIDTH + 1;       // difference vector width
	localparam int CZ_W   = 2 * RW;                // unscaled cross term
	localparam int XD_DLY = SQRT_STEPS - 2;        // x, d wait for |r2|
	localparam int TOTAL  = SQRT_STEPS + CORDIC_STEPS + 10;
	localparam int RSH    = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [63:0] HALF64 = 64'sd1 <<< (RSH - 1);
	localparam logic signed [63:0] LIM64  = (PI_Z + HALF64) >>> RSH;
	localparam logic signed [CORDIC_W-1:0] HALF = CORDIC_W'(HALF64);
	localparam logic signed [CORDIC_W-1:0] LIM  = CORDIC_W'(LIM64);
	localparam logic signed [CORDIC_W-1:0] PI_C = CORDIC_W'(PI_Z);

	// advance the whole pipe unless a finished beat is stuck at the output
	logic adv;
	logic [TOTAL-1:0] vld_q;

	assign adv       = !vld_q[TOTAL-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL-2:0], in_valid};
		end
	end

	// ---- stage 1: difference vectors r1, r2, r3 (index [vector][axis]) ----
	logic signed [RW-1:0] r_s1 [3][3];

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1[0][0] <= RW'(p1_x) - RW'(p2_x);
			r_s1[0][1] <= RW'(p1_y) - RW'(p2_y);
			r_s1[0][2] <= RW'(p1_z) - RW'(p2_z);
			r_s1[1][0] <= RW'(p2_x) - RW'(p3_x);
			r_s1[1][1] <= RW'(p2_y) - RW'(p3_y);
			r_s1[1][2] <= RW'(p2_z) - RW'(p3_z);
			r_s1[2][0] <= RW'(p3_x) - RW'(p4_x);
			r_s1[2][1] <= RW'(p3_y) - RW'(p4_y);
			r_s1[2][2] <= RW'(p3_z) - RW'(p4_z);
		end
	end

	// ---- stage 2: exact cross terms for the zero test, scale search ----
	logic signed [CZ_W-1:0] cza_s2 [2][3];
	logic signed [CZ_W-1:0] czb_s2 [2][3];
	logic signed [RW-1:0]   r_s2   [3][3];
	logic                   rgt_s2 [3];
	logic [SH_W-1:0]        amt_s2 [3];
	logic [63:0]            rmag   [3];
	logic [POS_W-1:0]       rpos   [3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			rmag[v] = '0;
			for (int c = 0; c < 3; c++) begin
				rmag[v] = rmag[v] | (r_s1[v][c][RW-1] ? 64'(-r_s1[v][c]) : 64'(r_s1[v][c]));
			end
			rpos[v] = lead_pos(rmag[v]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int v = 0; v < 2; v++) begin
				for (int c = 0; c < 3; c++) begin
					cza_s2[v][c] <= CZ_W'(r_s1[v][nxt1(c)]) * CZ_W'(r_s1[v+1][nxt2(c)]);
					czb_s2[v][c] <= CZ_W'(r_s1[v][nxt2(c)]) * CZ_W'(r_s1[v+1][nxt1(c)]);
				end
			end
			for (int v = 0; v < 3; v++) begin
				for (int c = 0; c < 3; c++) begin
					r_s2[v][c] <= r_s1[v][c];
				end
				rgt_s2[v] <= rpos[v] > POS_W'(SV_TOP);
				amt_s2[v] <= (rpos[v] > POS_W'(SV_TOP)) ? SH_W'(rpos[v] - POS_W'(SV_TOP))
				                                       : SH_W'(POS_W'(SV_TOP) - rpos[v]);
			end
		end
	end

	// ---- stage 3: degenerate test, scale each vector to 16 bits ----
	logic                    deg_s3;
	logic signed [SV_W-1:0]  sv_s3 [3][3];
	logic signed [63:0]      rwide [3][3];

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int c = 0; c < 3; c++) begin
				rwide[v][c] = rgt_s2[v] ? (64'(r_s2[v][c]) >>> amt_s2[v])
				                        : (64'(r_s2[v][c]) <<< amt_s2[v]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s3 <= ((cza_s2[0][0] == czb_s2[0][0]) && (cza_s2[0][1] == czb_s2[0][1]) &&
			           (cza_s2[0][2] == czb_s2[0][2])) ||
			          ((cza_s2[1][0] == czb_s2[1][0]) && (cza_s2[1][1] == czb_s2[1][1]) &&
			           (cza_s2[1][2] == czb_s2[1][2]));
			for (int v = 0; v < 3; v++) begin
				for (int c = 0; c < 3; c++) begin
					sv_s3[v][c] <= rwide[v][c][SV_W-1:0];
				end
			end
		end
	end

	// ---- stage 4: cross products of scaled vectors, squares of r2 ----
	logic                    deg_s4;
	logic signed [PRD_W-1:0] pa_s4 [2][3];
	logic signed [PRD_W-1:0] pb_s4 [2][3];
	logic signed [PRD_W-1:0] sq_s4 [3];
	logic signed [SV_W-1:0]  r1_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s4 <= deg_s3;
			for (int v = 0; v < 2; v++) begin
				for (int c = 0; c < 3; c++) begin
					pa_s4[v][c] <= PRD_W'(sv_s3[v][nxt1(c)]) * PRD_W'(sv_s3[v+1][nxt2(c)]);
					pb_s4[v][c] <= PRD_W'(sv_s3[v][nxt2(c)]) * PRD_W'(sv_s3[v+1][nxt1(c)]);
				end
			end
			for (int c = 0; c < 3; c++) begin
				sq_s4[c] <= PRD_W'(sv_s3[1][c]) * PRD_W'(sv_s3[1][c]);
				r1_s4[c] <= sv_s3[0][c];
			end
		end
	end

	// ---- stage 5: halved normals P1, P2 and r2 . r2 ----
	logic                   deg_s5;
	logic signed [N_W-1:0]  n_s5  [2][3];
	logic signed [SV_W-1:0] r1_s5 [3];
	logic [SQ_W-1:0]        r2sq_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s5 <= deg_s4;
			for (int v = 0; v < 2; v++) begin
				for (int c = 0; c < 3; c++) begin
					n_s5[v][c] <= N_W'((33'(pa_s4[v][c]) - 33'(pb_s4[v][c])) >>> 1);
				end
			end
			for (int c = 0; c < 3; c++) begin
				r1_s5[c] <= r1_s4[c];
			end
			r2sq_s5 <= SQ_W'(33'(sq_s4[0]) + 33'(sq_s4[1]) + 33'(sq_s4[2]));
		end
	end

	// ---- stage 6: dot product terms ----
	logic                   deg_s6;
	logic signed [XY_W-1:0] px_s6 [3];
	logic signed [D_W-1:0]  pd_s6 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s6 <= deg_s5;
			for (int c = 0; c < 3; c++) begin
				px_s6[c] <= XY_W'(n_s5[0][c]) * XY_W'(n_s5[1][c]);
				pd_s6[c] <= D_W'(r1_s5[c]) * D_W'(n_s5[1][c]);
			end
		end
	end

	// ---- stage 7: x = P1 . P2, d = r1 . P2 ----
	logic                   deg_s7;
	logic signed [XY_W-1:0] x_s7;
	logic signed [D_W-1:0]  d_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s7 <= deg_s6;
			x_s7   <= px_s6[0] + px_s6[1] + px_s6[2];
			d_s7   <= pd_s6[0] + pd_s6[1] + pd_s6[2];
		end
	end

	// ---- |r2|: one root bit per cell, from stage 6 to stage 5+SQRT_STEPS ----
	logic [SQ_W-1:0] sn [SQRT_STEPS+1];
	logic [SQ_W-1:0] sr [SQRT_STEPS+1];

	assign sn[0] = r2sq_s5;
	assign sr[0] = '0;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		dafp_sqrt_cell #(
			.K (SQRT_STEPS - 1 - i)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.n_in  (sn[i]),
			.r_in  (sr[i]),
			.n_out (sn[i+1]),
			.r_out (sr[i+1])
		);
	end

	// hold x, d and the flag alongside the root cells
	logic                   deg_dq [XD_DLY];
	logic signed [XY_W-1:0] x_dq   [XD_DLY];
	logic signed [D_W-1:0]  d_dq   [XD_DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_dq[0] <= deg_s7;
			x_dq[0]   <= x_s7;
			d_dq[0]   <= d_s7;
			for (int i = 1; i < XD_DLY; i++) begin
				deg_dq[i] <= deg_dq[i-1];
				x_dq[i]   <= x_dq[i-1];
				d_dq[i]   <= d_dq[i-1];
			end
		end
	end

	// ---- stage 22: |r2| * d as two partial products ----
	logic [LEN_W-1:0]       len;
	logic                   deg_s22;
	logic signed [XY_W-1:0] x_s22;
	logic [39:0]            ylo_s22;
	logic signed [40:0]     yhi_s22;

	assign len = sr[SQRT_STEPS][LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s22 <= deg_dq[XD_DLY-1];
			x_s22   <= x_dq[XD_DLY-1];
			ylo_s22 <= 40'(len) * 40'(d_dq[XD_DLY-1][23:0]);
			// upper half of d carries the sign
			yhi_s22 <= 41'(signed'({1'b0, len})) *
			           41'(signed'(d_dq[XD_DLY-1][D_W-1:24]));
		end
	end

	// ---- stage 23: y = floor(|r2| * d / 2) ----
	logic                   deg_s23;
	logic signed [XY_W-1:0] x_s23;
	logic signed [XY_W-1:0] y_s23;

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s23 <= deg_s22;
			x_s23   <= x_s22;
			y_s23   <= XY_W'(((65'(yhi_s22) <<< 24) + 65'(ylo_s22)) >>> 1);
		end
	end

	// ---- stage 24: find the common scale of x and y ----
	logic                   deg_s24;
	logic                   zero_s24;
	logic                   rgt_s24;
	logic [SH_W-1:0]        amt_s24;
	logic signed [XY_W-1:0] x_s24;
	logic signed [XY_W-1:0] y_s24;
	logic [XY_W-1:0]        xymag;
	logic [POS_W-1:0]       xypos;

	always_comb begin
		xymag = (x_s23[XY_W-1] ? XY_W'(-x_s23) : XY_W'(x_s23)) |
		        (y_s23[XY_W-1] ? XY_W'(-y_s23) : XY_W'(y_s23));
		xypos = lead_pos(xymag);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s24  <= deg_s23;
			zero_s24 <= xymag == '0;
			rgt_s24  <= xypos > POS_W'(XY_TOP);
			amt_s24  <= (xypos > POS_W'(XY_TOP)) ? SH_W'(xypos - POS_W'(XY_TOP))
			                                     : SH_W'(POS_W'(XY_TOP) - xypos);
			x_s24    <= x_s23;
			y_s24    <= y_s23;
		end
	end

	// ---- stage 25: apply scale, fold left half-plane onto the right ----
	flags_t                     flg_s25;
	logic signed [CORDIC_W-1:0] cx_s25;
	logic signed [CORDIC_W-1:0] cy_s25;
	logic signed [CORDIC_W-1:0] cz_s25;
	logic signed [XY_W-1:0]     xsh;
	logic signed [XY_W-1:0]     ysh;
	logic signed [CORDIC_W-1:0] xn;
	logic signed [CORDIC_W-1:0] yn;

	always_comb begin
		xsh = rgt_s24 ? (x_s24 >>> amt_s24) : (x_s24 <<< amt_s24);
		ysh = rgt_s24 ? (y_s24 >>> amt_s24) : (y_s24 <<< amt_s24);
		xn  = xsh[CORDIC_W-1:0];
		yn  = ysh[CORDIC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_s25.deg  <= deg_s24;
			flg_s25.zero <= zero_s24;
			if (xn[CORDIC_W-1]) begin
				cx_s25 <= -xn;
				cy_s25 <= -yn;
				cz_s25 <= yn[CORDIC_W-1] ? -PI_C : PI_C;
			end else begin
				cx_s25 <= xn;
				cy_s25 <= yn;
				cz_s25 <= '0;
			end
		end
	end

	// ---- CORDIC cells: drive y to zero, accumulate the angle ----
	logic signed [CORDIC_W-1:0] cx [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cy [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] cz [CORDIC_STEPS+1];

	assign cx[0] = cx_s25;
	assign cy[0] = cy_s25;
	assign cz[0] = cz_s25;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		dafp_cordic_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.en    (adv),
			.x_in  (cx[i]),
			.y_in  (cy[i]),
			.z_in  (cz[i]),
			.x_out (cx[i+1]),
			.y_out (cy[i+1]),
			.z_out (cz[i+1])
		);
	end

	flags_t flg_dq [CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			flg_dq[0] <= flg_s25;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				flg_dq[i] <= flg_dq[i-1];
			end
		end
	end

	// ---- output register: round half up, clamp to +-pi ----
	logic signed [CORDIC_W-1:0] zr;
	logic signed [CORDIC_W-1:0] zq;
	flags_t                     flg_out;

	assign flg_out = flg_dq[CORDIC_STEPS-1];

	always_comb begin
		zr = (cz[CORDIC_STEPS] + HALF) >>> RSH;
		if (zr > LIM) begin
			zq = LIM;
		end else if (zr < -LIM) begin
			zq = -LIM;
		end else begin
			zq = zr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle      <= (flg_out.deg || flg_out.zero) ? '0 : zq[ANGLE_W-1:0];
			degenerate <= flg_out.deg;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dafp_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dafp_sqrt_cell: one digit of a pipelined integer square root
// Resolves one root bit per cell (restoring form, bit = 4^K).
// ----------------------------------------------------------------------------
module dafp_sqrt_cell #(
	parameter int K = 0
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [dafp_pkg::SQ_W-1:0] n_in,
	input  wire logic [dafp_pkg::SQ_W-1:0] r_in,
	output logic      [dafp_pkg::SQ_W-1:0] n_out,
	output logic      [dafp_pkg::SQ_W-1:0] r_out
);
	import dafp_pkg::*;

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

	logic [SQ_W:0] trial;

	assign trial = {1'b0, r_in} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, n_in} >= trial) begin
				n_out <= n_in - trial[SQ_W-1:0];
				r_out <= (r_in >> 1) + BIT;
			end else begin
				n_out <= n_in;
				r_out <= r_in >> 1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dafp_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dafp_cordic_cell: one vectoring micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-IDX) and tracks the angle.
// ----------------------------------------------------------------------------
module dafp_cordic_cell #(
	parameter int IDX = 0
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [dafp_pkg::CORDIC_W-1:0] x_in,
	input  wire logic signed [dafp_pkg::CORDIC_W-1:0] y_in,
	input  wire logic signed [dafp_pkg::CORDIC_W-1:0] z_in,
	output logic      signed [dafp_pkg::CORDIC_W-1:0] x_out,
	output logic      signed [dafp_pkg::CORDIC_W-1:0] y_out,
	output logic      signed [dafp_pkg::CORDIC_W-1:0] z_out
);
	import dafp_pkg::*;

	localparam logic signed [CORDIC_W-1:0] ATAN = atan_z(IDX);

	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;

	assign dx = x_in >>> IDX;
	assign dy = y_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[CORDIC_W-1]) begin
				x_out <= x_in + dy;
				y_out <= y_in - dx;
				z_out <= z_in + ATAN;
			end else begin
				x_out <= x_in - dy;
				y_out <= y_in + dx;
				z_out <= z_in - ATAN;
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/dihedral_angle_from_four_points_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dihedral_angle_from_four_points_core_test: torsion angle kernel testbench
// Streams point quadruples through the kernel under random stalls on both
// channels. A bit-exact predictor computes each angle and degenerate flag,
// and each output beat is checked in order against those predictions.
// ----------------------------------------------------------------------------
module dihedral_angle_from_four_points_core_test;
	import dafp_pkg::*;

	localparam int CW        = COORD_WIDTH_D;
	localparam int STALL_CAP = 4000;   // cycles with no beat on either side
	localparam longint PI_FIX = 64'sd3373259426;
	localparam int RND_SHIFT = ZFRAC - ANGLE_FRAC_BITS_D;

	typedef logic signed [CW-1:0] quad_t [12];
	typedef struct {
		logic signed [ANGLE_W-1:0] ang;
		logic                      deg;
	} torsion_t;

	// atan(2^-i) with 30 fraction bits, truncated
	localparam longint ATAN_LUT [16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
	};

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [CW-1:0] pt [12];
	logic signed [ANGLE_W-1:0] angle;
	logic degenerate;

	torsion_t pending_angles [$];
	int  err_count = 0;
	bit  quiet = 0;       // no idling on either side
	int  idle_cycles = 0;

	dihedral_angle_from_four_points_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.p1_x(pt[0]), .p1_y(pt[1]), .p1_z(pt[2]),
		.p2_x(pt[3]), .p2_y(pt[4]), .p2_z(pt[5]),
		.p3_x(pt[6]), .p3_y(pt[7]), .p3_z(pt[8]),
		.p4_x(pt[9]), .p4_y(pt[10]), .p4_z(pt[11]),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle(angle), .degenerate(degenerate)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint labs(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// scale a difference vector so its largest magnitude sits in [2^14, 2^15)
	function automatic void scale_vec(ref longint v [3]);
		longint m;
		int s;
		m = labs(v[0]);
		if (labs(v[1]) > m) m = labs(v[1]);
		if (labs(v[2]) > m) m = labs(v[2]);
		if (m == 0) return;
		s = 0;
		if (m >= 32768) begin
			while ((m >>> s) >= 32768) s++;
			for (int i = 0; i < 3; i++) v[i] = v[i] >>> s;
		end else begin
			while ((m <<< s) < 16384) s++;
			for (int i = 0; i < 3; i++) v[i] = v[i] <<< s;
		end
	endfunction

	function automatic longint root_floor(input longint n);
		longint r, b;
		r = 0;
		b = 64'sh4000_0000_0000_0000;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint m, z, dx, dy;
		int s;
		m = (labs(x) > labs(y)) ? labs(x) : labs(y);
		z = 0;
		if (m == 0) return 0;
		s = 0;
		if (m >= (64'sd1 << 30)) begin
			while ((m >>> s) >= (64'sd1 << 30)) s++;
			x = x >>> s;
			y = y >>> s;
		end else begin
			while ((m <<< s) < (64'sd1 << 29)) s++;
			x = x <<< s;
			y = y <<< s;
		end
		if (x < 0) begin
			z = (y >= 0) ? PI_FIX : -PI_FIX;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS_D; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; z += ATAN_LUT[i];
			end else begin
				x -= dy; y += dx; z -= ATAN_LUT[i];
			end
		end
		return z;
	endfunction

	function automatic torsion_t torsion_of(input quad_t q);
		longint r1 [3], r2 [3], r3 [3], c1 [3], c2 [3];
		longint x, y, z, qa, lim, len;
		torsion_t res;
		for (int j = 0; j < 3; j++) begin
			r1[j] = longint'(q[j]) - longint'(q[3 + j]);
			r2[j] = longint'(q[3 + j]) - longint'(q[6 + j]);
			r3[j] = longint'(q[6 + j]) - longint'(q[9 + j]);
		end
		// exact cross products of the raw vectors fit in 64 bits
		for (int j = 0; j < 3; j++) begin
			c1[j] = r1[(j+1)%3] * r2[(j+2)%3] - r1[(j+2)%3] * r2[(j+1)%3];
			c2[j] = r2[(j+1)%3] * r3[(j+2)%3] - r2[(j+2)%3] * r3[(j+1)%3];
		end
		res.ang = '0;
		res.deg = 1'b0;
		if ((c1[0] == 0 && c1[1] == 0 && c1[2] == 0) ||
		    (c2[0] == 0 && c2[1] == 0 && c2[2] == 0)) begin
			res.deg = 1'b1;
			return res;
		end
		scale_vec(r1);
		scale_vec(r2);
		scale_vec(r3);
		for (int j = 0; j < 3; j++) begin
			c1[j] = (r1[(j+1)%3] * r2[(j+2)%3] - r1[(j+2)%3] * r2[(j+1)%3]) >>> 1;
			c2[j] = (r2[(j+1)%3] * r3[(j+2)%3] - r2[(j+2)%3] * r3[(j+1)%3]) >>> 1;
		end
		x = c1[0] * c2[0] + c1[1] * c2[1] + c1[2] * c2[2];
		len = root_floor(r2[0] * r2[0] + r2[1] * r2[1] + r2[2] * r2[2]);
		y = (len * (r1[0] * c2[0] + r1[1] * c2[1] + r1[2] * c2[2])) >>> 1;
		z = vector_angle(y, x);
		qa = (z + (64'sd1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
		lim = (PI_FIX + (64'sd1 << (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (qa > lim) qa = lim;
		if (qa < -lim) qa = -lim;
		res.ang = ANGLE_W'(qa);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Input side: send one beat, with an optional idle burst before it
	// ------------------------------------------------------------------
	task automatic send_quad(input quad_t q);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 12; i++) pt[i] <= q[i];
		// hold until the beat is taken
		do @(posedge clk); while (!in_ready);
		pending_angles.push_back(torsion_of(q));
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	// build a quadruple from four points given in whole units
	function automatic quad_t quad_units(input int c [12]);
		quad_t q;
		for (int i = 0; i < 12; i++) q[i] = CW'(c[i] * 4096);
		return q;
	endfunction

	function automatic quad_t random_quad(input int span);
		quad_t q;
		for (int i = 0; i < 12; i++) begin
			if (span >= CW) q[i] = CW'($urandom);
			else q[i] = CW'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
		end
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Output side: random ready bursts, and the in-order checker
	// ------------------------------------------------------------------
	initial begin
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			run = $urandom_range(1, 40);
			repeat (run) @(posedge clk);
			if (!quiet) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		torsion_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected beat angle=%0d degenerate=%0b",
					$time, angle, degenerate);
				err_count++;
			end else begin
				want = pending_angles.pop_front();
				if (angle !== want.ang) begin
					$display("%0t: angle expected %0d actual %0d", $time, want.ang, angle);
					err_count++;
				end
				if (degenerate !== want.deg) begin
					$display("%0t: degenerate expected %0b actual %0b",
						$time, want.deg, degenerate);
					err_count++;
				end
			end
		end
	end

	// watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_CAP) begin
				$display("dihedral_angle_from_four_points_core_test: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_extremes();
		quad_t q;
		for (int i = 0; i < 12; i++) q[i] = {1'b0, {(CW-1){1'b1}}};
		send_quad(q);                                   // all max: degenerate
		for (int i = 0; i < 12; i++) q[i] = {1'b1, {(CW-1){1'b0}}};
		send_quad(q);                                   // all min: degenerate
		for (int i = 0; i < 12; i++) q[i] = '0;
		send_quad(q);
		// alternate corners of the coordinate cube
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 12; i++)
				q[i] = (((i + k) % 3 == 0) ^ (i / 3 == k)) ?
					{1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			send_quad(q);
		end
		for (int i = 0; i < 12; i++) q[i] = (i % 2) ? CW'(-1) : CW'(1);
		send_quad(q);
	endtask

	task automatic test_degenerate();
		send_quad(quad_units('{0,0,0, 1,1,1, 2,2,2, 5,1,0}));   // first three collinear
		send_quad(quad_units('{3,1,0, 0,0,0, 1,0,0, 2,0,0}));   // last three collinear
		send_quad(quad_units('{1,2,3, 1,2,3, 4,0,1, 2,2,2}));   // repeated point
		send_quad(quad_units('{1,0,0, 0,0,0, 1,0,0, 0,1,0}));   // p3 equals p1
	endtask

	task automatic test_conformations();
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,-1,0}));  // trans: straight angle
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,1,0}));   // cis
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,0,1}));   // minus ninety
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,0,-1}));  // plus ninety
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,-1,-1})); // near trans, positive
		send_quad(quad_units('{0,1,0, 0,0,0, 1,0,0, 1,-1,1}));  // near trans, negative
		// tiny lengths: scaling up from a single lsb
		send_quad('{24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
		            24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd1, 24'sd1});
		// huge, nearly flat torsion
		send_quad('{24'sd8388607, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
		            -24'sd8388608, 24'sd1, 24'sd0, 24'sd8388607, 24'sd2, -24'sd1});
	endtask

	// mostly realistic geometry, some full-range noise and some broken shapes
	task automatic test_random(input int count);
		quad_t q;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) q = random_quad(15);                  // a few angstrom
			else if (pick < 7) q = random_quad($urandom_range(2, 23));
			else if (pick < 9) q = random_quad(CW);
			else begin
				q = random_quad(15);
				for (int j = 0; j < 3; j++) q[6 + j] = q[3 * $urandom_range(0, 3) + j];
			end
			send_quad(q);
		end
	endtask

	task automatic drain();
		end_stream();
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (SQRT_STEPS + CORDIC_STEPS_D + 30) @(posedge clk);
	endtask

	initial begin
		in_valid = 1'b0;
		for (int i = 0; i < 12; i++) pt[i] = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_degenerate();
		test_conformations();
		test_random(1400);
		quiet = 1;
		test_random(200);
		drain();

		if (err_count == 0)
			$display("dihedral_angle_from_four_points_core_test: clean");
		else
			$display("dihedral_angle_from_four_points_core_test: errors");
		$finish;
	end

endmodule
